// ===== rtl/srbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbb_pkg: shared types and constants for the start/release backoff broker
// Field widths, function and decision codes, register map, saturating add.
// ----------------------------------------------------------------------------
package srbb_pkg;

  localparam int TIME_BITS   = 40;   // deadline width, 32..64
  localparam int COUNT_BITS  = 16;   // attempt counter width, 8..32
  localparam int NOW_W       = 40;   // now_ms field width
  localparam int OUT_COUNT_W = 16;   // attempt_count field width
  localparam int BACKOFF_W   = 20;   // register and backoff width
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [BACKOFF_W-1:0] BACKOFF_FLOOR  = BACKOFF_W'(1000);
  localparam logic [BACKOFF_W-1:0] COOLDOWN_RST   = BACKOFF_W'(30000);
  localparam logic [BACKOFF_W-1:0] MIN_BACKOFF_RST = BACKOFF_W'(1000);
  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST = BACKOFF_W'(60000);

  typedef enum logic [1:0] {
    FUNC_ENSURE  = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_STOP    = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    DEC_IDLE           = 4'd0,
    DEC_MAINT          = 4'd1,
    DEC_SHUTDOWN       = 4'd2,
    DEC_HOLD           = 4'd3,
    DEC_RUNNING        = 4'd4,
    DEC_LIVE_UNKNOWN   = 4'd5,
    DEC_THROTTLED      = 4'd6,
    DEC_SHOULD_START   = 4'd7,
    DEC_STARTED        = 4'd8,
    DEC_START_FAILED   = 4'd9,
    DEC_REL_COOLDOWN   = 4'd10,
    DEC_SHOULD_RELEASE = 4'd11,
    DEC_RELEASED       = 4'd12,
    DEC_REL_FAILED     = 4'd13
  } decision_e;

  typedef enum logic [1:0] {
    REG_COOLDOWN    = 2'd0,
    REG_MIN_BACKOFF = 2'd1,
    REG_MAX_BACKOFF = 2'd2
  } reg_idx_e;

  typedef struct packed {
    func_e            func;
    logic [NOW_W-1:0] now_ms;
    logic             work_pending;
    logic             maint_ready;
    logic             stopping;
    logic             hold_admission;
    logic             alive_known;
    logic             owner_up;
    logic             governed;
    logic             success;
  } item_t;

  typedef struct packed {
    decision_e              decision;
    logic [OUT_COUNT_W-1:0] attempt_count;
  } result_t;

  // Settings seen by the decision core, plus the reinit strobe.
  typedef struct packed {
    logic [BACKOFF_W-1:0] cooldown;
    logic [BACKOFF_W-1:0] eff_min;
    logic [BACKOFF_W-1:0] eff_max;
    logic                 init;
    logic [BACKOFF_W-1:0] init_backoff;
  } cfg_t;

  function automatic logic [BACKOFF_W-1:0] eff_min_of(input logic [BACKOFF_W-1:0] m);
    return (m < BACKOFF_FLOOR) ? BACKOFF_FLOOR : m;
  endfunction

  function automatic logic [BACKOFF_W-1:0] eff_max_of(input logic [BACKOFF_W-1:0] lo,
                                                      input logic [BACKOFF_W-1:0] m);
    return (m < lo) ? lo : m;
  endfunction

  // now + delay, clamped to all ones on carry out
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [BACKOFF_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS+1)'(d);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

// ===== rtl/srbb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbb_if: event and result channels of the backoff broker
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface srbb_in_if;
  import srbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [NOW_W-1:0] now_ms;
  logic             work_pending;
  logic             maint_ready;
  logic             stopping;
  logic             hold_admission;
  logic             alive_known;
  logic             owner_up;
  logic             governed;
  logic             success;

  modport source (output valid, func, now_ms, work_pending, maint_ready, stopping,
                  hold_admission, alive_known, owner_up, governed, success,
                  input ready);
  modport sink (input valid, func, now_ms, work_pending, maint_ready, stopping,
                hold_admission, alive_known, owner_up, governed, success,
                output ready);
endinterface

interface srbb_out_if;
  import srbb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [3:0]             decision;
  logic [OUT_COUNT_W-1:0] attempt_count;

  modport source (output valid, decision, attempt_count, input ready);
  modport sink (input valid, decision, attempt_count, output ready);
endinterface

// ===== rtl/start_release_backoff_broker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_release_backoff_broker: start/release decisions with retry backoff
// Event register, decision core and result register around APB settings.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+-----------------------------------
//   in_i     | in  | valid / ready      | func, now_ms, status flags, success
//   out_o    | out | valid / ready      | decision, attempt_count
//   apb      | in  | psel/penable/pready| cooldown, min and max backoff regs
//
// One event per cycle sustained while results are taken; each event passes
// the event register, then the decision core updates state and loads the
// result register on the same edge.
// The event register frees whenever the result register empties or is
// drained in that cycle, so a waiting result never blocks intake of one word.
// Reset (rst_ni low, asynchronous) clears both valid flags and the state;
// a write to a mapped register resets the state, backoff to the new minimum.
// ----------------------------------------------------------------------------
module start_release_backoff_broker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  srbb_in_if.sink                     in_i,
  srbb_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srbb_pkg::APB_AW-1:0] paddr,
  input  logic [srbb_pkg::APB_DW-1:0] pwdata,
  output logic [srbb_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import srbb_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q, item_vld_d;
  result_t res_q;
  result_t res_d;
  logic    res_vld_q, res_vld_d;
  logic    in_fire;
  logic    advance;

  srbb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held event into the result register when that slot is free.
  assign advance    = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  srbb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
    end else if (advance) begin
      item_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (out_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers: load on intake and on advance, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.func           <= func_e'(in_i.func);
      item_q.now_ms         <= in_i.now_ms;
      item_q.work_pending   <= in_i.work_pending;
      item_q.maint_ready    <= in_i.maint_ready;
      item_q.stopping       <= in_i.stopping;
      item_q.hold_admission <= in_i.hold_admission;
      item_q.alive_known    <= in_i.alive_known;
      item_q.owner_up       <= in_i.owner_up;
      item_q.governed       <= in_i.governed;
      item_q.success        <= in_i.success;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_vld_q;
  assign out_o.decision      = res_q.decision;
  assign out_o.attempt_count = res_q.attempt_count;

endmodule

// ===== rtl/srbb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbb_cfg: APB register file for cooldown and backoff limits
// Holds the three registers, derives effective limits, strobes reinit.
// ----------------------------------------------------------------------------
module srbb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srbb_pkg::APB_AW-1:0]   paddr,
  input  logic [srbb_pkg::APB_DW-1:0]   pwdata,
  output logic [srbb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output srbb_pkg::cfg_t                cfg_o
);
  import srbb_pkg::*;

  logic [BACKOFF_W-1:0] cool_q, cool_d;
  logic [BACKOFF_W-1:0] min_q, min_d;
  logic [BACKOFF_W-1:0] max_q, max_d;
  logic                 wr;
  logic                 hit;
  logic [1:0]           idx;
  logic [BACKOFF_W-1:0] wval;
  logic [BACKOFF_W-1:0] eff_min_q;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;
  assign wval   = pwdata[BACKOFF_W-1:0];

  always_comb begin
    cool_d = cool_q;
    min_d  = min_q;
    max_d  = max_q;
    hit    = 1'b0;
    prdata = '0;
    unique case (idx)
      REG_COOLDOWN: begin
        prdata = APB_DW'(cool_q);
        if (wr) begin
          cool_d = wval;
          hit    = 1'b1;
        end
      end
      REG_MIN_BACKOFF: begin
        prdata = APB_DW'(min_q);
        if (wr) begin
          min_d = wval;
          hit   = 1'b1;
        end
      end
      REG_MAX_BACKOFF: begin
        prdata = APB_DW'(max_q);
        if (wr) begin
          max_d = wval;
          hit   = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_q <= COOLDOWN_RST;
      min_q  <= MIN_BACKOFF_RST;
      max_q  <= MAX_BACKOFF_RST;
    end else begin
      cool_q <= cool_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

  assign eff_min_q          = eff_min_of(min_q);
  assign cfg_o.cooldown     = cool_q;
  assign cfg_o.eff_min      = eff_min_q;
  assign cfg_o.eff_max      = eff_max_of(eff_min_q, max_q);
  assign cfg_o.init         = hit;
  assign cfg_o.init_backoff = eff_min_of(min_d);

endmodule

// ===== rtl/srbb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbb_core: decision chain and broker state
// Decides one event per step_i and updates deadlines, backoff and counter.
// ----------------------------------------------------------------------------
module srbb_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srbb_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  srbb_pkg::item_t   item_i,
  output srbb_pkg::result_t res_o
);
  import srbb_pkg::*;

  logic [TIME_BITS-1:0]  att_dl_q, att_dl_d;
  logic [TIME_BITS-1:0]  rel_dl_q, rel_dl_d;
  logic [BACKOFF_W-1:0]  backoff_q, backoff_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  started_q, started_d;
  logic [TIME_BITS-1:0]  now;
  logic [BACKOFF_W-1:0]  delay;
  logic [TIME_BITS-1:0]  deadline;
  logic [BACKOFF_W:0]    dbl;
  decision_e             dec;

  assign now = TIME_BITS'(item_i.now_ms);
  // A failed start waits the current backoff; everything else the cooldown.
  assign delay    = (item_i.func == FUNC_START && !item_i.success) ? backoff_q
                                                                    : cfg_i.cooldown;
  assign deadline = sat_add(now, delay);
  assign dbl      = {backoff_q, 1'b0};

  always_comb begin
    att_dl_d  = att_dl_q;
    rel_dl_d  = rel_dl_q;
    backoff_d = backoff_q;
    count_d   = count_q;
    started_d = started_q;
    dec       = DEC_IDLE;
    unique case (item_i.func)
      FUNC_ENSURE: begin
        if (!item_i.work_pending) begin
          backoff_d = cfg_i.eff_min;
          priority if (!started_q || !item_i.governed) begin
            dec = DEC_IDLE;
          end else if (!item_i.alive_known) begin
            dec = DEC_IDLE;
          end else if (!item_i.owner_up) begin
            started_d = 1'b0;
            dec       = DEC_IDLE;
          end else if (now < rel_dl_q) begin
            dec = DEC_REL_COOLDOWN;
          end else begin
            dec = DEC_SHOULD_RELEASE;
          end
        end else begin
          priority if (!item_i.maint_ready) begin
            dec = DEC_MAINT;
          end else if (item_i.stopping) begin
            dec = DEC_SHUTDOWN;
          end else if (item_i.hold_admission) begin
            dec = DEC_HOLD;
          end else if (!item_i.alive_known) begin
            dec = DEC_LIVE_UNKNOWN;
          end else if (item_i.owner_up) begin
            backoff_d = cfg_i.eff_min;
            dec       = DEC_RUNNING;
          end else if (now < att_dl_q) begin
            dec = DEC_THROTTLED;
          end else begin
            if (count_q != {COUNT_BITS{1'b1}}) begin
              count_d = count_q + COUNT_BITS'(1);
            end
            dec = DEC_SHOULD_START;
          end
        end
      end
      FUNC_START: begin
        att_dl_d = deadline;
        if (item_i.success) begin
          backoff_d = cfg_i.eff_min;
          started_d = 1'b1;
          dec       = DEC_STARTED;
        end else begin
          backoff_d = (dbl < {1'b0, cfg_i.eff_max}) ? dbl[BACKOFF_W-1:0] : cfg_i.eff_max;
          dec       = DEC_START_FAILED;
        end
      end
      FUNC_RELEASE: begin
        rel_dl_d = deadline;
        if (item_i.success) begin
          started_d = 1'b0;
          dec       = DEC_RELEASED;
        end else begin
          dec = DEC_REL_FAILED;
        end
      end
      FUNC_STOP: begin
        started_d = 1'b0;
        att_dl_d  = deadline;
        dec       = DEC_IDLE;
      end
      default: begin
        dec = DEC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_dl_q  <= '0;
      rel_dl_q  <= '0;
      backoff_q <= BACKOFF_FLOOR;
      count_q   <= '0;
      started_q <= 1'b0;
    end else if (cfg_i.init) begin
      att_dl_q  <= '0;
      rel_dl_q  <= '0;
      backoff_q <= cfg_i.init_backoff;
      count_q   <= '0;
      started_q <= 1'b0;
    end else if (step_i) begin
      att_dl_q  <= att_dl_d;
      rel_dl_q  <= rel_dl_d;
      backoff_q <= backoff_d;
      count_q   <= count_d;
      started_q <= started_d;
    end
  end

  assign res_o.decision      = dec;
  assign res_o.attempt_count = OUT_COUNT_W'(count_d);

endmodule

// ===== rtl/srbb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbb_checker: port-level checks for the backoff broker
// Result after intake, counter order, register readback and output hold under stall.
// ----------------------------------------------------------------------------
module srbb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [3:0]                  decision,
  input logic [srbb_pkg::OUT_COUNT_W-1:0] attempt_count,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [srbb_pkg::APB_AW-1:0] paddr,
  input logic [srbb_pkg::APB_DW-1:0] pwdata,
  input logic [srbb_pkg::APB_DW-1:0] prdata,
  input logic                        pready
);
  import srbb_pkg::*;

  logic in_fire;
  logic out_fire;
  logic cfg_wr;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Every accepted word is followed by a valid output word.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##2 out_valid)
    else $error("no result two cycles after intake");

  // Back-to-back results never lower the attempt count unless a write preceded.
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && $past(out_fire) && !$past(cfg_wr)) |-> attempt_count >= $past(attempt_count))
    else $error("attempt count went backward");

  // A cooldown write reads back on the next cycle.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[3:2] == REG_COOLDOWN) |=>
      (!(psel && !pwrite && paddr[3:2] == REG_COOLDOWN) ||
       prdata == APB_DW'($past(pwdata[BACKOFF_W-1:0]))))
    else $error("cooldown readback mismatch");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(decision) && $stable(attempt_count)))
    else $error("stalled result changed");

endmodule

bind start_release_backoff_broker srbb_checker u_srbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .decision      (out_o.decision),
  .attempt_count (out_o.attempt_count),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

// ===== bench/tb_start_release_backoff_broker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_start_release_backoff_broker: self-checking bench for the backoff broker
// Directed event rows, then random event streams under several register
// settings. An in-bench predictor follows every accepted event, and each
// decision word is checked field by field.
// ----------------------------------------------------------------------------
module tb_start_release_backoff_broker;
  import srbb_pkg::*;

  localparam logic [TIME_BITS-1:0] T_TOP = {TIME_BITS{1'b1}};
  localparam logic [1:0] REG_UNMAPPED = 2'd3;   // index past the last register
  localparam int RAND_PER_PHASE = 130;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 30;

  // Stimulus row: one event, plus a hand-typed decision where it is obvious.
  typedef struct packed {
    item_t                  ev;
    logic                   typed;
    decision_e              want_dec;
    logic [OUT_COUNT_W-1:0] want_cnt;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  srbb_in_if  ev_ch ();
  srbb_out_if dec_ch ();

  start_release_backoff_broker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (ev_ch),
    .out_o   (dec_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns period: low half, then high half
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and broker state as the block holds them
  // --------------------------------------------------------------------------
  logic [BACKOFF_W-1:0]  cooldown_reg;
  logic [BACKOFF_W-1:0]  min_reg;
  logic [BACKOFF_W-1:0]  max_reg;
  logic [TIME_BITS-1:0]  retry_at;       // earliest time for the next start
  logic [TIME_BITS-1:0]  release_at;     // earliest time for the next release
  logic [BACKOFF_W-1:0]  backoff_ms;     // delay armed by the next start failure
  logic [COUNT_BITS-1:0] starts_seen;    // saturating should-start count
  logic                  owner_ours;     // we started the owner ourselves
  decision_e             last_dec;       // steers the well-formed random stream

  result_t   pending_decisions[$];       // decisions still owed by the block
  stim_row_t stim_rows[$];
  result_t   seen_word;
  logic [TIME_BITS-1:0] wall_ms;

  int  faults      = 0;
  int  words_in    = 0;
  int  words_out   = 0;
  int  settings    = 1;
  int  holds_asked = 0;
  int  holds_done  = 0;
  int  hold_left   = 0;
  bit  tx_steady   = 1'b0;
  bit  rx_steady   = 1'b0;

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic flag_fault(input string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Minimum is floored at one second; the cap never sits below the minimum.
  function automatic logic [BACKOFF_W-1:0] floor_min();
    return (min_reg < BACKOFF_FLOOR) ? BACKOFF_FLOOR : min_reg;
  endfunction

  function automatic logic [BACKOFF_W-1:0] ceil_max();
    logic [BACKOFF_W-1:0] lo;
    lo = floor_min();
    return (max_reg < lo) ? lo : max_reg;
  endfunction

  // now + delay, pinned to the top of the time range on carry out
  function automatic logic [TIME_BITS-1:0] deadline_after(input logic [TIME_BITS-1:0] t,
                                                          input logic [BACKOFF_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + {{(TIME_BITS + 1 - BACKOFF_W){1'b0}}, d};
    return s[TIME_BITS] ? T_TOP : s[TIME_BITS-1:0];
  endfunction

  task automatic clear_broker_state();
    retry_at    = '0;
    release_at  = '0;
    backoff_ms  = floor_min();
    starts_seen = '0;
    owner_ours  = 1'b0;
    last_dec    = DEC_IDLE;
  endtask

  // Ensure: walk the priority chain over the status flags.
  function automatic decision_e judge_ensure(input item_t ev);
    if (!ev.work_pending) begin
      // no work: reset the backoff, then consider giving the owner back
      backoff_ms = floor_min();
      if (!owner_ours || !ev.governed || !ev.alive_known) return DEC_IDLE;
      if (!ev.owner_up) begin
        owner_ours = 1'b0;
        return DEC_IDLE;
      end
      return (ev.now_ms < release_at) ? DEC_REL_COOLDOWN : DEC_SHOULD_RELEASE;
    end
    if (!ev.maint_ready) return DEC_MAINT;
    if (ev.stopping) return DEC_SHUTDOWN;
    if (ev.hold_admission) return DEC_HOLD;
    if (!ev.alive_known) return DEC_LIVE_UNKNOWN;
    if (ev.owner_up) begin
      backoff_ms = floor_min();
      return DEC_RUNNING;
    end
    if (ev.now_ms < retry_at) return DEC_THROTTLED;
    if (starts_seen != {COUNT_BITS{1'b1}}) starts_seen++;
    return DEC_SHOULD_START;
  endfunction

  // Advance the predictor by one accepted event and return its decision word.
  function automatic result_t judge_event(input item_t ev);
    result_t              r;
    logic [BACKOFF_W:0]   doubled;
    logic [BACKOFF_W-1:0] cap;
    decision_e            d;
    d = DEC_IDLE;
    case (ev.func)
      FUNC_ENSURE: d = judge_ensure(ev);
      FUNC_START: begin
        if (ev.success) begin
          retry_at   = deadline_after(ev.now_ms, cooldown_reg);
          backoff_ms = floor_min();
          owner_ours = 1'b1;
          d          = DEC_STARTED;
        end else begin
          // arm with the current backoff, then double it up to the cap
          doubled    = {backoff_ms, 1'b0};
          cap        = ceil_max();
          retry_at   = deadline_after(ev.now_ms, backoff_ms);
          backoff_ms = (doubled < {1'b0, cap}) ? doubled[BACKOFF_W-1:0] : cap;
          d          = DEC_START_FAILED;
        end
      end
      FUNC_RELEASE: begin
        release_at = deadline_after(ev.now_ms, cooldown_reg);
        if (ev.success) begin
          owner_ours = 1'b0;
          d          = DEC_RELEASED;
        end else begin
          d = DEC_REL_FAILED;
        end
      end
      default: begin
        // explicit stop always answers idle
        owner_ours = 1'b0;
        retry_at   = deadline_after(ev.now_ms, cooldown_reg);
        d          = DEC_IDLE;
      end
    endcase
    last_dec        = d;
    r.decision      = d;
    r.attempt_count = starts_seen[OUT_COUNT_W-1:0];
    return r;
  endfunction

  // Any write to a mapped register keeps the value and restarts the state.
  task automatic note_reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] v);
    case (idx)
      REG_COOLDOWN:    cooldown_reg = v[BACKOFF_W-1:0];
      REG_MIN_BACKOFF: min_reg      = v[BACKOFF_W-1:0];
      REG_MAX_BACKOFF: max_reg      = v[BACKOFF_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNMAPPED) clear_broker_state();
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: setup cycle, then access cycle, completed on pready
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [BACKOFF_W-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== {{(APB_DW - BACKOFF_W){1'b0}}, want})
      flag_fault($sformatf("register %0d read back %0h, want %0h", idx, rd, want));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, idx, v, rd);
    note_reg_write(idx, v);
    if (idx != REG_UNMAPPED) check_reg(idx, v[BACKOFF_W-1:0]);
  endtask

  // Drop valid, drain every owed decision, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk_i);
    ev_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [APB_DW-1:0] cool, input logic [APB_DW-1:0] lo,
                              input logic [APB_DW-1:0] hi);
    settle();
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_MIN_BACKOFF, lo);
    write_reg(REG_MAX_BACKOFF, hi);
    settings++;
  endtask

  // --------------------------------------------------------------------------
  // Event sender: random gaps, hold the word until it is taken
  // --------------------------------------------------------------------------
  task automatic offer(input item_t ev, output result_t got);
    while (!tx_steady && chance(IDLE_PCT)) begin
      @(negedge clk_i);
      ev_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    ev_ch.valid          <= 1'b1;
    ev_ch.func           <= ev.func;
    ev_ch.now_ms         <= ev.now_ms;
    ev_ch.work_pending   <= ev.work_pending;
    ev_ch.maint_ready    <= ev.maint_ready;
    ev_ch.stopping       <= ev.stopping;
    ev_ch.hold_admission <= ev.hold_admission;
    ev_ch.alive_known    <= ev.alive_known;
    ev_ch.owner_up       <= ev.owner_up;
    ev_ch.governed       <= ev.governed;
    ev_ch.success        <= ev.success;
    @(posedge clk_i);
    while (!ev_ch.ready) @(posedge clk_i);
    got = judge_event(ev);
    pending_decisions.push_back(got);
    words_in++;
  endtask

  // Mostly well-formed traffic: time moves forward, a should-start is followed
  // by a start result and a should-release by a release result. The rest is
  // noise with every field random.
  function automatic item_t draw_event();
    item_t       ev;
    logic [63:0] raw;
    if (chance(15)) begin
      raw = {$urandom(), $urandom()};
      ev  = raw[$bits(item_t)-1:0];
      return ev;
    end
    ev = '0;
    if ($urandom_range(39) == 0)
      wall_ms = T_TOP - TIME_BITS'($urandom_range(30000));   // run into the top
    else if ($urandom_range(9) == 0)
      wall_ms = wall_ms + TIME_BITS'($urandom_range(250000));
    else
      wall_ms = wall_ms + TIME_BITS'($urandom_range(4000));
    ev.now_ms  = wall_ms;
    ev.success = chance(50);
    case (last_dec)
      DEC_SHOULD_START:   ev.func = FUNC_START;
      DEC_SHOULD_RELEASE: ev.func = FUNC_RELEASE;
      default: begin
        ev.func           = chance(4) ? FUNC_STOP : FUNC_ENSURE;
        ev.work_pending   = chance(75);
        ev.maint_ready    = chance(90);
        ev.stopping       = chance(8);
        ev.hold_admission = chance(8);
        ev.alive_known    = chance(92);
        ev.owner_up       = chance(25);
        ev.governed       = chance(70);
      end
    endcase
    return ev;
  endfunction

  task automatic run_random(input int n, input bit with_pressure);
    result_t got;
    for (int i = 0; i < n; i++) begin
      // a calm stretch: neither side idles
      if (i == 40) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (i == 90) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      // long receiver hold-off while the sender keeps offering
      if (with_pressure && i == 100) holds_asked++;
      offer(draw_event(), got);
    end
  endtask

  task automatic add_row(input func_e f, input logic [TIME_BITS-1:0] t, input logic [6:0] flags,
                         input logic ok, input logic typed, input decision_e d,
                         input int unsigned cnt);
    stim_row_t r;
    r          = '0;
    r.ev.func  = f;
    r.ev.now_ms = t;
    {r.ev.work_pending, r.ev.maint_ready, r.ev.stopping, r.ev.hold_admission,
     r.ev.alive_known, r.ev.owner_up, r.ev.governed} = flags;
    r.ev.success = ok;
    r.typed      = typed;
    r.want_dec   = d;
    r.want_cnt   = OUT_COUNT_W'(cnt);
    stim_rows.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Decision receiver: random stalls, calm stretches, and counted hold-offs
  // --------------------------------------------------------------------------
  initial begin
    dec_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        dec_ch.ready <= 1'b0;
      end else if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLDOFF_CYCLES - 1;
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= rx_steady || !chance(IDLE_PCT);
      end
    end
  end

  // Check each accepted decision word against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && dec_ch.valid && dec_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        flag_fault($sformatf("decision %0d count %0d with nothing owed",
                             dec_ch.decision, dec_ch.attempt_count));
      end else begin
        seen_word = pending_decisions.pop_front();
        words_out++;
        if (dec_ch.decision !== seen_word.decision ||
            dec_ch.attempt_count !== seen_word.attempt_count)
          flag_fault($sformatf("decision exp %0d got %0d, count exp %0d got %0d",
                               seen_word.decision, dec_ch.decision,
                               seen_word.attempt_count, dec_ch.attempt_count));
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    result_t got;
    stim_row_t r;

    // drive every input to a known value from time zero
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    ev_ch.valid          = 1'b0;
    ev_ch.func           = FUNC_ENSURE;
    ev_ch.now_ms         = '0;
    ev_ch.work_pending   = 1'b0;
    ev_ch.maint_ready    = 1'b0;
    ev_ch.stopping       = 1'b0;
    ev_ch.hold_admission = 1'b0;
    ev_ch.alive_known    = 1'b0;
    ev_ch.owner_up       = 1'b0;
    ev_ch.governed       = 1'b0;
    ev_ch.success        = 1'b0;
    wall_ms              = '0;

    cooldown_reg = COOLDOWN_RST;
    min_reg      = MIN_BACKOFF_RST;
    max_reg      = MAX_BACKOFF_RST;
    clear_broker_state();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // register values straight out of reset
    check_reg(REG_COOLDOWN, COOLDOWN_RST);
    check_reg(REG_MIN_BACKOFF, MIN_BACKOFF_RST);
    check_reg(REG_MAX_BACKOFF, MAX_BACKOFF_RST);

    // Directed rows under reset settings (cooldown 30 s, backoff 1 s .. 60 s).
    // flags: {pending, maint, stopping, hold, known, up, governed}
    //       func          now        flags       ok    typed decision          count
    add_row(FUNC_ENSURE,  '0,        7'b0000000, 1'b0, 1'b1, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  '0,        7'b1000000, 1'b0, 1'b1, DEC_MAINT,          0);
    add_row(FUNC_ENSURE,  '0,        7'b1110000, 1'b0, 1'b1, DEC_SHUTDOWN,       0);
    add_row(FUNC_ENSURE,  '0,        7'b1101000, 1'b0, 1'b1, DEC_HOLD,           0);
    add_row(FUNC_ENSURE,  '0,        7'b1100000, 1'b0, 1'b1, DEC_LIVE_UNKNOWN,   0);
    add_row(FUNC_ENSURE,  '0,        7'b1100110, 1'b0, 1'b1, DEC_RUNNING,        0);
    add_row(FUNC_ENSURE,  '0,        7'b1100100, 1'b0, 1'b1, DEC_SHOULD_START,   1);
    add_row(FUNC_START,   40'd100,   7'b0000000, 1'b0, 1'b1, DEC_START_FAILED,   1);
    add_row(FUNC_ENSURE,  40'd500,   7'b1100100, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  40'd1100,  7'b1100100, 1'b0, 1'b0, DEC_IDLE,           0);
    // failure at the top of time: the retry deadline pins to the top
    add_row(FUNC_START,   T_TOP,     7'b0000000, 1'b0, 1'b1, DEC_START_FAILED,   2);
    add_row(FUNC_ENSURE,  T_TOP - 1, 7'b1100100, 1'b0, 1'b1, DEC_THROTTLED,      2);
    add_row(FUNC_ENSURE,  T_TOP,     7'b1100100, 1'b0, 1'b1, DEC_SHOULD_START,   3);
    add_row(FUNC_START,   40'd2000,  7'b0000000, 1'b1, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  '0,        7'b0000111, 1'b1, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_RELEASE, 40'd5000,  7'b0000000, 1'b0, 1'b1, DEC_REL_FAILED,     3);
    add_row(FUNC_ENSURE,  40'd6000,  7'b0000111, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  40'd7000,  7'b0000011, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  40'd7000,  7'b0000110, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  T_TOP,     7'b0000111, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_RELEASE, T_TOP,     7'b0000000, 1'b1, 1'b1, DEC_RELEASED,       3);
    add_row(FUNC_START,   40'd10,    7'b0000000, 1'b1, 1'b0, DEC_IDLE,           0);
    // owner gone while governed: drop our claim, then stay idle
    add_row(FUNC_ENSURE,  40'd20,    7'b0000101, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_ENSURE,  40'd30,    7'b0000111, 1'b0, 1'b0, DEC_IDLE,           0);
    add_row(FUNC_STOP,    T_TOP,     7'b1111111, 1'b1, 1'b1, DEC_IDLE,           3);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      offer(r.ev, got);
      if (r.typed && (got.decision != r.want_dec || got.attempt_count != r.want_cnt))
        flag_fault($sformatf("row %0d predicted %0d/%0d, table says %0d/%0d", i,
                             got.decision, got.attempt_count, r.want_dec, r.want_cnt));
    end
    run_random(RAND_PER_PHASE, 1'b0);

    // lowest settings: minimum and cap both floor at one second
    program_regs(32'd0, 32'd0, 32'd0);
    run_random(RAND_PER_PHASE, 1'b1);

    // highest settings, written with junk above the register width
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(RAND_PER_PHASE, 1'b0);

    // cap below the minimum; a write past the last register changes nothing
    program_regs(32'd1500, 32'd2500, 32'd700);
    write_reg(REG_UNMAPPED, 32'h0001_2345);
    run_random(RAND_PER_PHASE, 1'b0);

    // short cooldown with a narrow backoff range
    program_regs(32'd3000, 32'd1000, 32'd9000);
    run_random(RAND_PER_PHASE, 1'b0);

    settle();
    $display("Covered %0d events (%0d directed, the rest random) under %0d settings.",
             words_in, stim_rows.size(), settings);
    $display("Checked %0d decision words, one long receiver hold-off; %0d faults seen.",
             words_out, faults);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
